// ===== rtl/assert_macros.svh =====
// Assertion macros used by clipped_rectangle_fill, the RTL file that carries checks.
// No dependencies; pulled in with `include where needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crf_pkg.sv =====
// Shared types and constants of the clipped rectangle fill engine.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package crf_pkg;

    localparam int MAX_SCREEN_SIDE = 4096;
    localparam int COORD_W         = 13;
    localparam int SIDE_W          = 16;
    localparam int ADDR_W          = 32;
    localparam int COLOR_W         = 32;
    localparam int PITCH_W         = 16;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 32;
    localparam int PIXEL_BYTES     = 4;

    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_FRAME_BASE    = 4'd0,
        REG_SCREEN_WIDTH  = 4'd1,
        REG_SCREEN_HEIGHT = 4'd2,
        REG_ROW_PITCH     = 4'd3
    } reg_index_t;

    typedef struct packed
    {
        kind_t                      kind;
        logic signed [SIDE_W-1:0]   rect_x;
        logic signed [SIDE_W-1:0]   rect_y;
        logic signed [SIDE_W-1:0]   rect_width;
        logic signed [SIDE_W-1:0]   rect_height;
        logic        [COLOR_W-1:0]  fill_color;
    } rect_cmd_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]  write_address;
        logic [COLOR_W-1:0] write_data;
        logic               last_pixel;
    } pixel_write_t;

endpackage

// ===== rtl/crf_channels.sv =====
// Valid/ready channel interfaces of the clipped rectangle fill engine.
// Depends on crf_pkg for field widths and the kind code.
`timescale 1ns / 1ps

interface crf_cmd_if;
    logic                               valid;
    logic                               ready;
    crf_pkg::kind_t                     kind;
    logic signed [crf_pkg::SIDE_W-1:0]  rect_x;
    logic signed [crf_pkg::SIDE_W-1:0]  rect_y;
    logic signed [crf_pkg::SIDE_W-1:0]  rect_width;
    logic signed [crf_pkg::SIDE_W-1:0]  rect_height;
    logic        [crf_pkg::COLOR_W-1:0] fill_color;

    modport source (output valid, kind, rect_x, rect_y, rect_width, rect_height, fill_color,
                    input ready);
    modport sink (input valid, kind, rect_x, rect_y, rect_width, rect_height, fill_color,
                  output ready);
endinterface

interface crf_pix_if;
    logic                         valid;
    logic                         ready;
    logic [crf_pkg::ADDR_W-1:0]   write_address;
    logic [crf_pkg::COLOR_W-1:0]  write_data;
    logic                         last_pixel;

    modport source (output valid, write_address, write_data, last_pixel, input ready);
    modport sink (input valid, write_address, write_data, last_pixel, output ready);
endinterface

interface crf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [crf_pkg::CFG_INDEX_W-1:0]  index;
    logic [crf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/clipped_rectangle_fill.sv =====
// Clipped rectangle fill engine, 32 bits per pixel: top level.
// A step request is held in the command register and its pixel write then in
// the pixel register, from which the consumer takes it.
// Throughput: one request per cycle; the command register and the pixel
// register each advance every cycle unless the pixel consumer stalls.
// Reset (rst_n, asynchronous, active low) empties both registers, goes idle
// and clears the configuration registers to zero.
// Depends on crf_pkg, the crf channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clipped_rectangle_fill
(
    input  logic         clk,
    input  logic         rst_n,
    crf_cmd_if.sink      cmd,
    crf_pix_if.source    pix,
    crf_cfg_if.sink      cfg
);

    // ------------------------------------------------------------------
    // Configuration registers. A write lands at once; the walk reads the
    // pitch live, the base and the screen size only at a start.
    // ------------------------------------------------------------------
    logic [crf_pkg::ADDR_W-1:0]  frame_base_reg;
    logic [crf_pkg::COORD_W-1:0] screen_width_reg;
    logic [crf_pkg::COORD_W-1:0] screen_height_reg;
    logic [crf_pkg::PITCH_W-1:0] row_pitch_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg    <= '0;
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
            row_pitch_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            // Indexes beyond the register list are dropped by the default arm.
            unique case (cfg.index)
                crf_pkg::REG_FRAME_BASE:    frame_base_reg    <= cfg.data[crf_pkg::ADDR_W-1:0];
                crf_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg.data[crf_pkg::COORD_W-1:0];
                crf_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg.data[crf_pkg::COORD_W-1:0];
                crf_pkg::REG_ROW_PITCH:     row_pitch_reg     <= cfg.data[crf_pkg::PITCH_W-1:0];
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Command register: holds one accepted request until it is processed.
    // ------------------------------------------------------------------
    logic               cmd_valid_reg;
    crf_pkg::rect_cmd_t cmd_reg;

    // Pixel register: holds one finished write until the consumer takes it.
    logic                  pix_valid_reg;
    crf_pkg::pixel_write_t pix_reg;

    // Walk state.
    logic                        busy_reg;
    logic [crf_pkg::COORD_W-1:0] cur_col_reg;
    logic [crf_pkg::COORD_W-1:0] first_col_reg;
    logic [crf_pkg::COORD_W-1:0] end_col_reg;
    logic [crf_pkg::COORD_W-1:0] cur_row_reg;
    logic [crf_pkg::COORD_W-1:0] end_row_reg;
    logic [crf_pkg::ADDR_W-1:0]  row_start_address_reg;
    logic [crf_pkg::ADDR_W-1:0]  pixel_address_reg;
    logic [crf_pkg::COLOR_W-1:0] held_color_reg;

    // A step while busy yields a pixel and needs a free pixel register;
    // every other request is absorbed without output and never stalls.
    logic pix_free;
    logic emits;
    logic process;

    assign pix_free  = !pix_valid_reg || pix.ready;
    assign emits     = (cmd_reg.kind == crf_pkg::KIND_STEP) && busy_reg;
    assign process   = cmd_valid_reg && (!emits || pix_free);
    assign cmd.ready = !cmd_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            cmd_reg.kind        <= cmd.kind;
            cmd_reg.rect_x      <= cmd.rect_x;
            cmd_reg.rect_y      <= cmd.rect_y;
            cmd_reg.rect_width  <= cmd.rect_width;
            cmd_reg.rect_height <= cmd.rect_height;
            cmd_reg.fill_color  <= cmd.fill_color;
        end
    end

    // ------------------------------------------------------------------
    // Start: clip the rectangle against the screen. Work in 18-bit signed
    // so that x + w never overflows and the bounds compare exactly.
    // ------------------------------------------------------------------
    localparam int CLIP_W = crf_pkg::SIDE_W + 2;

    logic [crf_pkg::COORD_W-1:0] sw_clamp;
    logic [crf_pkg::COORD_W-1:0] sh_clamp;
    logic signed [CLIP_W-1:0]    x_s;
    logic signed [CLIP_W-1:0]    y_s;
    logic signed [CLIP_W-1:0]    w_s;
    logic signed [CLIP_W-1:0]    h_s;
    logic signed [CLIP_W-1:0]    x1_s;
    logic signed [CLIP_W-1:0]    y1_s;
    logic signed [CLIP_W-1:0]    sw_s;
    logic signed [CLIP_W-1:0]    sh_s;
    logic signed [CLIP_W-1:0]    x0_c;
    logic signed [CLIP_W-1:0]    y0_c;
    logic signed [CLIP_W-1:0]    x1_c;
    logic signed [CLIP_W-1:0]    y1_c;
    logic                        rect_ok;
    logic [crf_pkg::COORD_W+crf_pkg::PITCH_W-1:0] row_offset;
    logic [crf_pkg::ADDR_W-1:0]  start_address;

    // Saturate the screen size to the largest supported side.
    assign sw_clamp = ({19'd0, screen_width_reg} > 32'(crf_pkg::MAX_SCREEN_SIDE))
                      ? crf_pkg::COORD_W'(crf_pkg::MAX_SCREEN_SIDE) : screen_width_reg;
    assign sh_clamp = ({19'd0, screen_height_reg} > 32'(crf_pkg::MAX_SCREEN_SIDE))
                      ? crf_pkg::COORD_W'(crf_pkg::MAX_SCREEN_SIDE) : screen_height_reg;

    assign x_s  = {{2{cmd_reg.rect_x[crf_pkg::SIDE_W-1]}}, cmd_reg.rect_x};
    assign y_s  = {{2{cmd_reg.rect_y[crf_pkg::SIDE_W-1]}}, cmd_reg.rect_y};
    assign w_s  = {{2{cmd_reg.rect_width[crf_pkg::SIDE_W-1]}}, cmd_reg.rect_width};
    assign h_s  = {{2{cmd_reg.rect_height[crf_pkg::SIDE_W-1]}}, cmd_reg.rect_height};
    assign x1_s = x_s + w_s;
    assign y1_s = y_s + h_s;
    assign sw_s = {{(CLIP_W-crf_pkg::COORD_W){1'b0}}, sw_clamp};
    assign sh_s = {{(CLIP_W-crf_pkg::COORD_W){1'b0}}, sh_clamp};

    assign x0_c = (x_s < 0) ? '0 : x_s;
    assign y0_c = (y_s < 0) ? '0 : y_s;
    assign x1_c = (x1_s > sw_s) ? sw_s : x1_s;
    assign y1_c = (y1_s > sh_s) ? sh_s : y1_s;

    // Drop empty rectangles, those wholly off screen, and those empty after clipping.
    assign rect_ok = (w_s > 0) && (h_s > 0)
                     && (x1_s > 0) && (y1_s > 0) && (x_s < sw_s) && (y_s < sh_s)
                     && (x1_c > x0_c) && (y1_c > y0_c);

    // First pixel address: base + y0 * pitch + x0 * 4, wrapping at 32 bits.
    assign row_offset    = y0_c[crf_pkg::COORD_W-1:0] * row_pitch_reg;
    assign start_address = frame_base_reg
                           + {{(crf_pkg::ADDR_W-crf_pkg::COORD_W-crf_pkg::PITCH_W){1'b0}},
                              row_offset}
                           + {{(crf_pkg::ADDR_W-crf_pkg::COORD_W-2){1'b0}},
                              x0_c[crf_pkg::COORD_W-1:0], 2'b00};

    // ------------------------------------------------------------------
    // Step: emit the current pixel, then advance in row-major order.
    // ------------------------------------------------------------------
    logic [crf_pkg::COORD_W:0] col_inc;
    logic [crf_pkg::COORD_W:0] row_inc;
    logic                      last_w;
    logic                      row_wrap;
    logic [crf_pkg::ADDR_W-1:0] next_row_address;

    assign col_inc  = {1'b0, cur_col_reg} + 1'b1;
    assign row_inc  = {1'b0, cur_row_reg} + 1'b1;
    assign row_wrap = col_inc >= {1'b0, end_col_reg};
    assign last_w   = row_wrap && (row_inc >= {1'b0, end_row_reg});
    // Pitch is read live, so a new value takes effect at the next row advance.
    assign next_row_address = row_start_address_reg
                              + {{(crf_pkg::ADDR_W-crf_pkg::PITCH_W){1'b0}}, row_pitch_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg              <= 1'b0;
            cur_col_reg           <= '0;
            first_col_reg         <= '0;
            end_col_reg           <= '0;
            cur_row_reg           <= '0;
            end_row_reg           <= '0;
            row_start_address_reg <= '0;
            pixel_address_reg     <= '0;
            held_color_reg        <= '0;
        end
        else if (process)
        begin
            if (cmd_reg.kind == crf_pkg::KIND_START)
            begin
                // Ignore a start while busy.
                if (!busy_reg && rect_ok)
                begin
                    busy_reg              <= 1'b1;
                    first_col_reg         <= x0_c[crf_pkg::COORD_W-1:0];
                    cur_col_reg           <= x0_c[crf_pkg::COORD_W-1:0];
                    end_col_reg           <= x1_c[crf_pkg::COORD_W-1:0];
                    cur_row_reg           <= y0_c[crf_pkg::COORD_W-1:0];
                    end_row_reg           <= y1_c[crf_pkg::COORD_W-1:0];
                    row_start_address_reg <= start_address;
                    pixel_address_reg     <= start_address;
                    held_color_reg        <= cmd_reg.fill_color;
                end
            end
            else if (busy_reg)
            begin
                if (last_w)
                begin
                    busy_reg <= 1'b0;
                end
                else if (row_wrap)
                begin
                    cur_col_reg           <= first_col_reg;
                    cur_row_reg           <= row_inc[crf_pkg::COORD_W-1:0];
                    row_start_address_reg <= next_row_address;
                    pixel_address_reg     <= next_row_address;
                end
                else
                begin
                    cur_col_reg       <= col_inc[crf_pkg::COORD_W-1:0];
                    pixel_address_reg <= pixel_address_reg
                                         + crf_pkg::ADDR_W'(crf_pkg::PIXEL_BYTES);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel register: load on an emitting step, drop once taken.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (process && emits)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emits)
        begin
            pix_reg.write_address <= pixel_address_reg;
            pix_reg.write_data    <= held_color_reg;
            pix_reg.last_pixel    <= last_w;
        end
    end

    assign pix.valid         = pix_valid_reg;
    assign pix.write_address = pix_reg.write_address;
    assign pix.write_data    = pix_reg.write_data;
    assign pix.last_pixel    = pix_reg.last_pixel;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_walk_in_bounds, clk, rst_n, busy_reg,
        (cur_col_reg < end_col_reg) && (cur_row_reg < end_row_reg)
            && (first_col_reg <= cur_col_reg),
        "walk position outside the clipped rectangle")
    `ASSERT_NEXT(a_last_goes_idle, clk, rst_n, process && emits && last_w,
        !busy_reg && pix_valid_reg && pix_reg.last_pixel,
        "last pixel did not end the rectangle")
    `ASSERT_NEXT(a_stalled_cmd_holds, clk, rst_n, cmd_valid_reg && !process,
        cmd_valid_reg && $stable(cmd_reg) && $stable(busy_reg),
        "stalled request changed or was lost")

endmodule
